>>> rtl/core/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants for the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    typedef enum logic [2:0] {
        MD_ADD = 3'd0,
        MD_SUB = 3'd1,
        MD_MUL = 3'd2,
        MD_DIV = 3'd3,
        MD_POW = 3'd4,
        MD_NEG = 3'd5,
        MD_INV = 3'd6,
        MD_RED = 3'd7
    } t_mode;

    // control of the serial Horner engine
    typedef struct packed {
        logic clr;
        logic step;
        logic din;
    } t_hrn_ctl;

    localparam int OPND_W  = 30;
    localparam int EXP_W   = 63;
    localparam int WIDE_W  = 64;
    localparam int RES_W   = 30;
    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 32;
    localparam int MODE_W  = 3;

endpackage

>>> rtl/core/mau_horner.sv
// ----------------------------------------------------------------------------
// mau_horner
// Bit-serial modular Horner engine: acc <- (2*acc + din*x) mod m per step.
// ----------------------------------------------------------------------------
module mau_horner #(
    parameter int MOD_BITS = 30
) (
    input  logic                  i_clk,
    input  mau_pkg::t_hrn_ctl     i_ctl,
    input  logic [MOD_BITS-1:0]   i_x,
    input  logic [MOD_BITS-1:0]   i_mod,
    output logic [MOD_BITS-1:0]   o_acc
);
    import mau_pkg::*;

    localparam int MW = MOD_BITS + 1;

    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] n_acc;
    logic [MW-1:0]       w_dbl;
    logic [MW-1:0]       w_dbl_r;
    logic [MW-1:0]       w_sum;
    logic [MW-1:0]       w_sum_r;
    logic [MW-1:0]       w_m;

    always_comb begin
        w_m     = {1'b0, i_mod};
        w_dbl   = {r_acc, 1'b0};
        w_dbl_r = (w_dbl >= w_m) ? (w_dbl - w_m) : w_dbl;
        w_sum   = w_dbl_r + (i_ctl.din ? {1'b0, i_x} : '0);
        w_sum_r = (w_sum >= w_m) ? (w_sum - w_m) : w_sum;
        n_acc   = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            n_acc = w_sum_r[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/core/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular ALU: add, sub, mul, div, pow, negate, inverse, wide reduction.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer when            Contents
// s_axis    in   tvalid & tready          tuser: mode; tdata: a, b, exponent, wide
// m_axis    out  tvalid & tready          tdata: result; tuser: no_inverse, equal
// cfg       in   i_cfg_we                 modulus
//
// Operands are first reduced serially. Add/sub/negate are then formed directly
// from the reduced operands; mul and reduce run the Horner engine one bit a
// cycle; pow runs square-and-multiply passes over the exponent bits, LSB first;
// inverse/div run extended Euclid, each step a bit-serial restoring division.
// One item at a time; the next item is taken while a result waits.
// Reset is synchronous, active low; modulus resets to 1.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
    parameter int MOD_BITS = 30
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [MOD_BITS-1:0]          i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: operand_a[29:0], operand_b[59:30], exponent[122:60],
    //        wide_value[186:123], zeros above
    input  logic [mau_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [mau_pkg::MODE_W-1:0]   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: result[29:0], zeros above
    output logic [mau_pkg::M_DATA_W-1:0] m_axis_tdata,
    // tuser: no_inverse[0], operands_equal[1]
    output logic [1:0]                   m_axis_tuser
);
    import mau_pkg::*;

    localparam int MW = MOD_BITS + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RUN  = 6'b000010,
        S_NEXT = 6'b000100,
        S_EUC  = 6'b001000,
        S_POW  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        PH_A   = 3'd0,
        PH_B   = 3'd1,
        PH_W   = 3'd2,
        PH_MUL = 3'd3,
        PH_PM  = 3'd4,
        PH_SQ  = 3'd5,
        PH_QS  = 3'd6
    } t_phase;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    t_mode               r_mode, n_mode;
    logic [MOD_BITS-1:0] r_mod;
    logic [OPND_W-1:0]   r_b_raw, n_b_raw;
    logic [EXP_W-1:0]    r_e, n_e;
    logic [WIDE_W-1:0]   r_wmag, n_wmag;
    logic                r_wneg, n_wneg;
    logic [63:0]         r_sh, n_sh;
    logic [6:0]          r_cnt, n_cnt;
    logic [MOD_BITS-1:0] r_a, n_a;
    logic [MOD_BITS-1:0] r_r0, n_r0, r_r1, n_r1;
    logic [MOD_BITS-1:0] r_s0, n_s0, r_s1, n_s1;
    logic [MOD_BITS-1:0] r_rem, n_rem;
    logic [MOD_BITS-1:0] r_res, n_res, r_pm, n_pm;
    logic                r_flag, n_flag, r_eq, n_eq;
    logic                r_ovalid, n_ovalid;
    logic [RES_W-1:0]    r_ores, n_ores;
    logic                r_oflag, n_oflag, r_oeq, n_oeq;

    logic [MOD_BITS-1:0] w_m, w_one, w_acc, w_x;
    logic [MW-1:0]       w_rem_t, w_rem_n, w_sum;
    logic                w_qbit, w_accept;
    logic [MOD_BITS-1:0] w_add, w_sub, w_neg, w_red, w_s1n;
    logic [WIDE_W-1:0]   w_wide;
    t_hrn_ctl            w_hctl;

    assign w_m   = (r_mod == '0) ? MOD_BITS'(1) : r_mod;
    assign w_one = (w_m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_wide        = s_axis_tdata[186:123];

    // restoring divider step for Euclid
    assign w_rem_t = {r_rem, r_sh[63]};
    assign w_qbit  = (w_rem_t >= {1'b0, r_r1});
    assign w_rem_n = w_qbit ? (w_rem_t - {1'b0, r_r1}) : w_rem_t;

    // second operand is taken straight from the accumulator at the end of its pass
    assign w_sum = {1'b0, r_a} + {1'b0, w_acc};
    assign w_add = (w_sum >= {1'b0, w_m}) ? MOD_BITS'(w_sum - {1'b0, w_m})
                                           : w_sum[MOD_BITS-1:0];
    assign w_sub = (r_a >= w_acc) ? (r_a - w_acc) : (r_a + (w_m - w_acc));
    assign w_neg = (r_a == '0) ? '0 : (w_m - r_a);
    assign w_red = (r_wneg && w_acc != '0) ? (w_m - w_acc) : w_acc;
    assign w_s1n = (r_s0 >= w_acc) ? (r_s0 - w_acc) : (r_s0 + (w_m - w_acc));

    always_comb begin
        case (r_phase)
            PH_MUL:  w_x = r_a;
            PH_PM:   w_x = r_res;
            PH_SQ:   w_x = r_pm;
            PH_QS:   w_x = r_s1;
            default: w_x = w_one;
        endcase
    end

    mau_horner #(
        .MOD_BITS (MOD_BITS)
    ) u_horner (
        .i_clk (i_clk),
        .i_ctl (w_hctl),
        .i_x   (w_x),
        .i_mod (w_m),
        .o_acc (w_acc)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_b_raw  = r_b_raw;
        n_e      = r_e;
        n_wmag   = r_wmag;
        n_wneg   = r_wneg;
        n_sh     = r_sh;
        n_cnt    = r_cnt;
        n_a      = r_a;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_rem    = r_rem;
        n_res    = r_res;
        n_pm     = r_pm;
        n_flag   = r_flag;
        n_eq     = r_eq;
        n_ovalid = r_ovalid;
        n_ores   = r_ores;
        n_oflag  = r_oflag;
        n_oeq    = r_oeq;
        w_hctl   = '0;
        w_hctl.din = (r_phase == PH_QS) ? w_qbit : r_sh[63];

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = t_mode'(s_axis_tuser);
                    n_b_raw = s_axis_tdata[59:30];
                    n_e     = s_axis_tdata[122:60];
                    n_wneg  = w_wide[63];
                    n_wmag  = w_wide[63] ? (~w_wide + 64'd1) : w_wide;
                    n_eq    = (s_axis_tdata[29:0] == s_axis_tdata[59:30]);
                    n_flag  = 1'b0;
                    n_sh    = {s_axis_tdata[29:0], 34'd0};
                    n_cnt   = 7'd30;
                    n_phase = PH_A;
                    w_hctl.clr = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                w_hctl.step = 1'b1;
                n_sh  = {r_sh[62:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_phase == PH_QS) begin
                    n_rem = w_rem_n[MOD_BITS-1:0];
                end
                if (r_cnt == 7'd1) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                case (r_phase)
                    PH_A: begin
                        n_a     = w_acc;
                        n_sh    = {r_b_raw, 34'd0};
                        n_cnt   = 7'd30;
                        n_phase = PH_B;
                        w_hctl.clr = 1'b1;
                        n_state = S_RUN;
                    end
                    PH_B: begin
                        case (r_mode)
                            MD_ADD: begin
                                n_res = w_add;
                                n_state = S_DONE;
                            end
                            MD_SUB: begin
                                n_res = w_sub;
                                n_state = S_DONE;
                            end
                            MD_NEG: begin
                                n_res = w_neg;
                                n_state = S_DONE;
                            end
                            MD_MUL: begin
                                n_sh    = {w_acc, {(64-MOD_BITS){1'b0}}};
                                n_cnt   = 7'(MOD_BITS);
                                n_phase = PH_MUL;
                                w_hctl.clr = 1'b1;
                                n_state = S_RUN;
                            end
                            MD_DIV, MD_INV: begin
                                n_r0 = w_m;
                                n_r1 = (r_mode == MD_DIV) ? w_acc : r_a;
                                n_s0 = '0;
                                n_s1 = w_one;
                                n_state = S_EUC;
                            end
                            MD_POW: begin
                                n_res = w_one;
                                n_pm  = r_a;
                                n_state = S_POW;
                            end
                            default: begin
                                n_sh    = r_wmag;
                                n_cnt   = 7'd64;
                                n_phase = PH_W;
                                w_hctl.clr = 1'b1;
                                n_state = S_RUN;
                            end
                        endcase
                    end
                    PH_W: begin
                        n_res = w_red;
                        n_state = S_DONE;
                    end
                    PH_MUL: begin
                        n_res = w_acc;
                        n_state = S_DONE;
                    end
                    PH_PM: begin
                        n_res   = w_acc;
                        n_sh    = {r_pm, {(64-MOD_BITS){1'b0}}};
                        n_cnt   = 7'(MOD_BITS);
                        n_phase = PH_SQ;
                        w_hctl.clr = 1'b1;
                        n_state = S_RUN;
                    end
                    PH_SQ: begin
                        n_pm = w_acc;
                        n_e  = {1'b0, r_e[EXP_W-1:1]};
                        n_state = S_POW;
                    end
                    default: begin
                        n_r0 = r_r1;
                        n_r1 = r_rem;
                        n_s0 = r_s1;
                        n_s1 = w_s1n;
                        n_state = S_EUC;
                    end
                endcase
            end
            S_EUC: begin
                if (r_r1 == '0) begin
                    if (r_r0 != MOD_BITS'(1)) begin
                        n_flag = 1'b1;
                        n_res  = '0;
                        n_state = S_DONE;
                    end else if (r_mode == MD_DIV) begin
                        n_sh    = {r_s0, {(64-MOD_BITS){1'b0}}};
                        n_cnt   = 7'(MOD_BITS);
                        n_phase = PH_MUL;
                        w_hctl.clr = 1'b1;
                        n_state = S_RUN;
                    end else begin
                        n_res = r_s0;
                        n_state = S_DONE;
                    end
                end else begin
                    n_rem   = '0;
                    n_sh    = {r_r0, {(64-MOD_BITS){1'b0}}};
                    n_cnt   = 7'(MOD_BITS);
                    n_phase = PH_QS;
                    w_hctl.clr = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_POW: begin
                if (r_e == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_sh    = {r_pm, {(64-MOD_BITS){1'b0}}};
                    n_cnt   = 7'(MOD_BITS);
                    n_phase = r_e[0] ? PH_PM : PH_SQ;
                    w_hctl.clr = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ores   = RES_W'(r_res);
                    n_oflag  = r_flag;
                    n_oeq    = r_eq;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mod    <= MOD_BITS'(1);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_mode  <= n_mode;
        r_b_raw <= n_b_raw;
        r_e     <= n_e;
        r_wmag  <= n_wmag;
        r_wneg  <= n_wneg;
        r_sh    <= n_sh;
        r_cnt   <= n_cnt;
        r_a     <= n_a;
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_s0    <= n_s0;
        r_s1    <= n_s1;
        r_rem   <= n_rem;
        r_res   <= n_res;
        r_pm    <= n_pm;
        r_flag  <= n_flag;
        r_eq    <= n_eq;
        r_ores  <= n_ores;
        r_oflag <= n_oflag;
        r_oeq   <= n_oeq;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_ores};
    assign m_axis_tuser  = {r_oeq, r_oflag};

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (w_acc < w_m))
        else $error("serial accumulator out of residue range");

    a_euc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EUC) |-> (r_s0 < w_m && r_s1 < w_m && r_r1 < r_r0))
        else $error("Euclid state out of range");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_flag) |-> (r_res == '0))
        else $error("missing inverse with non-zero result");

endmodule
